// ===== sv/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern search block.
`timescale 1ns / 1ps

package wbps_pkg;

    // Fixed field widths
    localparam int BYTE_W       = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 3;
    localparam int WILD_W       = 32;
    localparam int LEN_W        = 6;
    localparam int OFS_OUT_W    = 32;
    localparam int PAT_REGS     = 4;
    localparam int PAT_BYTES    = 32;   // configurable pattern bytes
    localparam int PAT_IDX_W    = 5;

    // Parameter defaults
    localparam int DEF_MAX_PATTERN = 32;
    localparam int DEF_OFFSET_BITS = 32;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PAT0 = 3'd0,
        CFG_PAT1 = 3'd1,
        CFG_PAT2 = 3'd2,
        CFG_PAT3 = 3'd3,
        CFG_WILD = 3'd4,
        CFG_LEN  = 3'd5
    } t_cfg_idx;

    // Per-cell control, common to the whole chain
    typedef struct packed {
        logic shift;   // accepted beat: move bytes one cell down
        logic clear;   // last beat: empty the window
    } t_cell_ctl;

    // One result item
    typedef struct packed {
        logic                 found;
        logic [OFS_OUT_W-1:0] offset;
    } t_result;

endpackage

// ===== sv/wbps_cell.sv =====
// One window cell: holds the byte of a fixed age and compares the byte entering it.
`timescale 1ns / 1ps

module wbps_cell #(
    parameter int AGE = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  wbps_pkg::t_cell_ctl                    i_ctl,
    input  logic [wbps_pkg::BYTE_W-1:0]            i_byte,
    input  logic [wbps_pkg::PAT_BYTES*wbps_pkg::BYTE_W-1:0] i_pattern,
    input  logic [wbps_pkg::WILD_W-1:0]            i_wild,
    input  logic [wbps_pkg::LEN_W-1:0]             i_len,
    output logic [wbps_pkg::BYTE_W-1:0]            o_byte,
    output logic                                   o_match
);
    import wbps_pkg::*;

    logic [BYTE_W-1:0]    r_byte;
    logic [BYTE_W-1:0]    n_byte;
    logic                 active;
    logic [LEN_W-1:0]     pos_full;
    logic [PAT_IDX_W-1:0] pos;
    logic [BYTE_W-1:0]    pat_byte;

    // Pattern position that lines up with this age for the current length
    assign active   = i_len > LEN_W'(AGE);
    assign pos_full = i_len - LEN_W'(1) - LEN_W'(AGE);
    assign pos      = pos_full[PAT_IDX_W-1:0];
    assign pat_byte = i_pattern[pos*BYTE_W +: BYTE_W];

    // Compare on the byte that enters this cell with the beat
    assign o_match = !active || i_wild[pos] || (i_byte == pat_byte);

    // Window storage
    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== sv/wbps_obuf.sv =====
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module wbps_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wbps_pkg::t_result   i_data,
    output logic                o_ready,
    output logic                o_valid,
    output wbps_pkg::t_result   o_data,
    input  logic                i_pop_ready
);
    import wbps_pkg::*;

    logic    r_ov, n_ov;
    logic    r_sv, n_sv;
    t_result r_od, n_od;
    t_result r_sd, n_sd;
    logic    pop;

    assign pop     = r_ov && i_pop_ready;
    assign o_ready = !r_sv;

    // Refill the output register from skid first, then from the new beat
    always_comb begin
        n_ov = r_ov;
        n_sv = r_sv;
        n_od = r_od;
        n_sd = r_sd;
        if (!r_ov || pop) begin
            if (r_sv) begin
                n_ov = 1'b1;
                n_od = r_sd;
                n_sv = i_push;
                n_sd = i_data;
            end else begin
                n_ov = i_push;
                n_od = i_data;
            end
        end else if (i_push) begin
            n_sv = 1'b1;
            n_sd = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        r_sd <= n_sd;
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

// ===== sv/wildcard_byte_pattern_search.sv =====
// Top level of the wildcard byte pattern search: config, cell chain, scan control.
//
//  Channel   Dir  Handshake        Payload
//  s_axis    in   tvalid/tready    tdata[7:0] byte_value, tlast is_last
//  m_axis    out  tvalid/tready    tdata[31:0] match_offset, tuser found
//  cfg       in   i_cfg_we         i_cfg_addr register index, i_cfg_wdata value
//
// One byte beat is taken every cycle while s_axis_tready is high; the compare
// of all window cells against the pattern and the result decision happen in
// the cycle the beat is accepted, and the result is registered in the buffer.
// The output register and a skid register hold up to two results, so input keeps
// flowing while one result waits; s_axis_tready drops only when both are full.
// Reset is synchronous and clears the window, byte count, flag and result buffer.
`timescale 1ns / 1ps

module wildcard_byte_pattern_search #(
    parameter int MAX_PATTERN = wbps_pkg::DEF_MAX_PATTERN,
    parameter int OFFSET_BITS = wbps_pkg::DEF_OFFSET_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: [7:0] byte_value
    input  logic [wbps_pkg::BYTE_W-1:0]       s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: [31:0] match_offset
    output logic [wbps_pkg::OFS_OUT_W-1:0]    m_axis_tdata,
    // tuser: [0] found
    output logic                              m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_we,
    input  logic [wbps_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import wbps_pkg::*;

    localparam int CELLS = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_pat [PAT_REGS];
    logic [WILD_W-1:0]     r_wild;
    logic [LEN_W-1:0]      r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PAT_REGS; k++) begin
                r_pat[k] <= '0;
            end
            r_wild <= '0;
            r_len  <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_PAT0: r_pat[0] <= i_cfg_wdata;
                CFG_PAT1: r_pat[1] <= i_cfg_wdata;
                CFG_PAT2: r_pat[2] <= i_cfg_wdata;
                CFG_PAT3: r_pat[3] <= i_cfg_wdata;
                CFG_WILD: r_wild   <= i_cfg_wdata[WILD_W-1:0];
                CFG_LEN:  r_len    <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Length in use: zero means one, clipped to the window size
    logic [LEN_W-1:0]                len_used;
    logic [PAT_BYTES*BYTE_W-1:0]     pattern;

    always_comb begin
        if (r_len == '0) begin
            len_used = LEN_W'(1);
        end else if (r_len > LEN_W'(CELLS)) begin
            len_used = LEN_W'(CELLS);
        end else begin
            len_used = r_len;
        end
    end

    assign pattern = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};

    // Beat handshake and chain control
    logic      accept;
    t_cell_ctl ctl;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign ctl.shift = accept;
    assign ctl.clear = accept && s_axis_tlast;

    // Cell chain: cell 0 takes the new byte, each next cell its neighbor's byte
    logic [BYTE_W-1:0] cell_in  [CELLS];
    logic [BYTE_W-1:0] cell_out [CELLS];
    logic [CELLS-1:0]  cell_match;

    genvar a;
    generate
        for (a = 0; a < CELLS; a++) begin : g_cell
            if (a == 0) begin : g_head
                assign cell_in[a] = s_axis_tdata;
            end else begin : g_link
                assign cell_in[a] = cell_out[a-1];
            end
            wbps_cell #(
                .AGE (a)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (ctl),
                .i_byte    (cell_in[a]),
                .i_pattern (pattern),
                .i_wild    (r_wild),
                .i_len     (len_used),
                .o_byte    (cell_out[a]),
                .o_match   (cell_match[a])
            );
        end
    endgenerate

    // Byte count and report flag
    logic [OFFSET_BITS-1:0] r_seen, n_seen;
    logic                   r_reported, n_reported;
    logic [OFFSET_BITS-1:0] seen_inc;
    logic [OFFSET_BITS-1:0] len_ext;
    logic [OFFSET_BITS-1:0] diff;
    logic [OFS_OUT_W-1:0]   ofs_out;
    logic                   counting;
    logic                   hit;
    logic                   res_valid;
    t_result                res;

    assign counting = r_seen != {OFFSET_BITS{1'b1}};
    assign seen_inc = r_seen + OFFSET_BITS'(1);
    assign len_ext  = OFFSET_BITS'(len_used);
    assign diff     = seen_inc - len_ext;

    generate
        if (OFFSET_BITS >= OFS_OUT_W) begin : g_ofs_trunc
            assign ofs_out = diff[OFS_OUT_W-1:0];
        end else begin : g_ofs_ext
            assign ofs_out = {{(OFS_OUT_W-OFFSET_BITS){1'b0}}, diff};
        end
    endgenerate

    assign hit = counting && !r_reported && (seen_inc >= len_ext) && (&cell_match);

    // Result decision and next scan state
    always_comb begin
        n_seen     = r_seen;
        n_reported = r_reported;
        res_valid  = 1'b0;
        res.found  = 1'b0;
        res.offset = '0;
        if (accept) begin
            if (counting) begin
                n_seen = seen_inc;
            end
            if (hit) begin
                res_valid  = 1'b1;
                res.found  = 1'b1;
                res.offset = ofs_out;
                n_reported = 1'b1;
            end else if (s_axis_tlast && !r_reported) begin
                res_valid = 1'b1;
            end
            if (s_axis_tlast) begin
                n_seen     = '0;
                n_reported = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else begin
            r_seen     <= n_seen;
            r_reported <= n_reported;
        end
    end

    // Result buffer
    t_result out_res;

    wbps_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_data      (res),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (out_res),
        .i_pop_ready (m_axis_tready)
    );

    assign m_axis_tdata = out_res.offset;
    assign m_axis_tuser = out_res.found;

    // Checks
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tlast) |=> (r_seen == '0 && !r_reported))
        else $error("scan state not cleared after last beat");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> !r_reported)
        else $error("second match in one scan");

    a_seen_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tlast) |=> (r_seen >= $past(r_seen)))
        else $error("byte count went backward");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

// ===== dv/wildcard_byte_pattern_search_tb.sv =====
// Self-checking testbench for the wildcard byte pattern search block.
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_tb;
    import wbps_pkg::*;

    localparam int WIN_BYTES    = DEF_MAX_PATTERN;
    localparam int PAT_CAP      = (DEF_MAX_PATTERN < PAT_BYTES) ? DEF_MAX_PATTERN : PAT_BYTES;
    localparam int COUNT_W      = DEF_OFFSET_BITS;
    localparam int RANDOM_BEATS = 800;
    localparam int CALM_BEATS   = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int LIMIT_NS     = 1000000;

    // Indexes outside the register map; writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    // Predicts match reports from accepted bytes and checks the output stream
    class match_scoreboard;
        logic [CFG_DATA_W-1:0] pat_reg [PAT_REGS];
        logic [WILD_W-1:0]     wild;
        logic [LEN_W-1:0]      len_reg;
        logic [BYTE_W-1:0]     window [WIN_BYTES];
        logic [COUNT_W-1:0]    seen;
        bit                    reported;
        t_result               pending_results [$];
        int                    errors;

        function new();
            int k;
            for (k = 0; k < PAT_REGS; k++) pat_reg[k] = '0;
            wild    = '0;
            len_reg = 6'd1;
            errors  = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            int k;
            for (k = 0; k < WIN_BYTES; k++) window[k] = '0;
            seen     = '0;
            reported = 1'b0;
        endfunction

        // Length actually compared: zero counts as one, capped at the window
        function int eff_len();
            int n;
            n = len_reg;
            if (n == 0) n = 1;
            if (n > PAT_CAP) n = PAT_CAP;
            return n;
        endfunction

        function logic [BYTE_W-1:0] pat_byte(int j);
            return pat_reg[j / 8][(j % 8) * 8 +: 8];
        endfunction

        function void note_config(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_PAT0: pat_reg[0] = v;
                CFG_PAT1: pat_reg[1] = v;
                CFG_PAT2: pat_reg[2] = v;
                CFG_PAT3: pat_reg[3] = v;
                CFG_WILD: wild = v[WILD_W-1:0];
                CFG_LEN:  len_reg = v[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // One accepted byte beat: shift window, test match, handle end of image
        function void scan_byte(logic [BYTE_W-1:0] b, logic last);
            int      n;
            int      j;
            int      k;
            bit      hit;
            t_result r;
            n = eff_len();
            for (k = WIN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = b;
            if (seen != '1) begin
                seen = seen + 1'b1;
                if (!reported && seen >= n) begin
                    hit = 1'b1;
                    for (j = 0; j < n; j++)
                        if (!wild[j] && window[n-1-j] != pat_byte(j)) hit = 1'b0;
                    if (hit) begin
                        r.found  = 1'b1;
                        r.offset = OFS_OUT_W'(seen - n);
                        pending_results = {pending_results, r};
                        reported = 1'b1;
                    end
                end
            end
            if (last) begin
                if (!reported) begin
                    r.found  = 1'b0;
                    r.offset = '0;
                    pending_results = {pending_results, r};
                end
                clear_scan();
            end
        endfunction

        function void check_result(logic found, logic [OFS_OUT_W-1:0] ofs);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: found=%0b match_offset=0x%0h", found, ofs);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0b, actual %0b", want.found, found);
                errors++;
            end
            if (ofs !== want.offset) begin
                $error("match_offset: expected 0x%0h, actual 0x%0h", want.offset, ofs);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic [BYTE_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OFS_OUT_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    match_scoreboard sb;
    bit              no_idle  = 1'b0;
    bit              hold_req = 1'b0;
    bit              narrow   = 1'b0;
    int              rnd_beats = 0;
    int              stall_left = 0;
    int              hold_left  = 0;

    wildcard_byte_pattern_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] byte_value
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [31:0] match_offset
        .m_axis_tuser  (m_axis_tuser),    // [0] found
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Overall time limit
    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // Narrow mode draws from a tiny alphabet so accidental matches happen
    function automatic logic [BYTE_W-1:0] rand_byte();
        return narrow ? BYTE_W'($urandom_range(0, 3)) : BYTE_W'($urandom);
    endfunction

    // Result side: check accepted beats, then pick next tready
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            m_axis_tready <= (hold_left == 0 && stall_left == 0);
        end
    end

    // One byte beat, with an optional idle burst ahead of it
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic l);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.scan_byte(b, l);
    endtask

    // Stop sending and let every outstanding result drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high so back-to-back writes need one assignment per edge
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.note_config(idx, v);
    endtask

    task automatic end_config();
        i_cfg_we <= 1'b0;
    endtask

    // New pattern, mask and length, biased toward short patterns
    task automatic random_config();
        logic [CFG_DATA_W-1:0] v;
        int                    k;
        int                    r;
        int                    len_val;
        narrow = ($urandom_range(0, 9) < 3);
        for (r = 0; r < PAT_REGS; r++) begin
            v = {$urandom, $urandom};
            if (narrow)
                for (k = 0; k < 8; k++) v[k*8 +: 8] = BYTE_W'($urandom_range(0, 3));
            case (r)
                0: write_reg(CFG_PAT0, v);
                1: write_reg(CFG_PAT1, v);
                2: write_reg(CFG_PAT2, v);
                default: write_reg(CFG_PAT3, v);
            endcase
        end
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v[WILD_W-1:0] = '0;
            1: v[WILD_W-1:0] = '1;
            2, 3: v[WILD_W-1:0] = $urandom & $urandom;
            default: ;
        endcase
        write_reg(CFG_WILD, v);
        case ($urandom_range(0, 9))
            0: len_val = 0;
            1: len_val = $urandom_range(33, 63);
            2, 3: len_val = $urandom_range(9, 32);
            default: len_val = $urandom_range(1, 8);
        endcase
        v = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
        v[LEN_W-1:0] = LEN_W'(len_val);
        write_reg(CFG_LEN, v);
        if ($urandom_range(0, 4) == 0)
            write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI,
                      {$urandom, $urandom});
        end_config();
    endtask

    // One image: noise, a clean embedded pattern, or a pattern with a flipped bit
    task automatic send_image(input bit close);
        logic [BYTE_W-1:0] img [$];
        logic [BYTE_W-1:0] b;
        int                kind;
        int                n;
        int                j;
        int                flip;
        kind = $urandom_range(0, 9);
        n    = sb.eff_len();
        flip = $urandom_range(0, n - 1);
        if (kind < 2) begin
            repeat ($urandom_range(1, 24)) img = {img, rand_byte()};
        end else begin
            repeat ($urandom_range(0, 10)) img = {img, rand_byte()};
            for (j = 0; j < n; j++) begin
                b = sb.wild[j] ? rand_byte() : sb.pat_byte(j);
                if (kind < 4 && j == flip) b = b ^ (8'h01 << $urandom_range(0, 7));
                img = {img, b};
            end
            repeat ($urandom_range(0, 6)) img = {img, rand_byte()};
        end
        for (j = 0; j < img.size(); j++)
            send_beat(img[j], close && (j == img.size() - 1));
        rnd_beats += img.size();
    endtask

    // Main sequence
    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config: one-byte pattern 0x00
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);       // second hit in same image stays silent
        send_beat(8'hFF, 1'b1);
        send_beat(8'hFF, 1'b1);       // single byte, not found
        send_beat(8'h00, 1'b1);       // hit on the last byte at offset zero

        // Four-byte pattern with a wildcard in position one
        wait_idle();
        write_reg(CFG_PAT0, 64'h0000_0000_A55A_FF00);
        write_reg(CFG_WILD, 64'h0000_0000_0000_0002);
        write_reg(CFG_LEN, 64'd4);
        end_config();
        send_beat(8'h00, 1'b0);       // image shorter than the pattern
        send_beat(8'hFF, 1'b0);
        send_beat(8'h5A, 1'b1);
        send_beat(8'h11, 1'b0);       // match ends on the final byte
        send_beat(8'h00, 1'b0);
        send_beat(8'h77, 1'b0);
        send_beat(8'h5A, 1'b0);
        send_beat(8'hA5, 1'b1);

        // Length zero behaves as length one
        wait_idle();
        write_reg(CFG_PAT0, 64'h0000_0000_0000_0042);
        write_reg(CFG_LEN, 64'd0);
        end_config();
        send_beat(8'h42, 1'b1);

        // Oversized length clamps to the full window; unmapped writes are dropped
        wait_idle();
        write_reg(CFG_WILD, '1);
        write_reg(CFG_LEN, 64'd63);
        write_reg(CFG_UNMAPPED_LO, '0);
        write_reg(CFG_UNMAPPED_HI, '0);
        end_config();
        send_beat(8'h42, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h42, 1'b1);

        // Backpressure: receiver holds off while one-byte images keep coming
        wait_idle();
        write_reg(CFG_LEN, 64'd1);
        end_config();
        narrow   = 1'b1;
        hold_req = 1'b1;
        repeat (12) send_beat(rand_byte(), 1'b1);

        // Random phases
        while (rnd_beats < RANDOM_BEATS) begin
            wait_idle();
            no_idle = (rnd_beats >= RANDOM_BEATS - CALM_BEATS);
            random_config();
            repeat ($urandom_range(1, 4)) send_image($urandom_range(0, 9) != 0);
        end

        // Close any open image, then drain
        wait_idle();
        no_idle = 1'b1;
        send_beat(rand_byte(), 1'b1);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 4) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
